>>> design/hrhs_pkg.sv
package hrhs_pkg;

	// Line limit; the window spans two lines
	localparam int LINE_BYTES = 80;
	localparam logic [7:0] WINDOW = 8'(2 * LINE_BYTES);
	localparam logic [7:0] MAX_LINE = 8'(LINE_BYTES - 2);

	// Character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Patterns over the recent bytes, newest byte lowest
	localparam logic [39:0] PAT_HTTP = 40'h2048545450;   // " HTTP" before '/'
	localparam logic [15:0] PAT_SCHEME = 16'h3A2F;       // ":/" before '/'
	localparam logic [31:0] PAT_HOST = 32'h686F7374;     // "host", lower case
	localparam logic [31:0] CASE_FOLD = 32'h20202020;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic       found;
		logic [7:0] host_start;
		logic [6:0] host_length;
	} host_info_t;

	// Parser match flags
	typedef struct packed {
		logic colon_ok;
		logic colon;
		logic slash;
		logic scheme;
		logic stop;
		logic begin_seen;
	} match_flags_t;

endpackage

>>> design/hrhs_parser.sv
module hrhs_parser import hrhs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  byte_item_t item,
	output host_info_t result
);

	typedef enum logic [2:0] {
		PH_PRE    = 3'd0,
		PH_TARGET = 3'd1,
		PH_WAIT   = 3'd2,
		PH_LINE2  = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	phase_t       ph_q, ph_d;
	logic [7:0]   pos_q, pos_d;
	logic [39:0]  recent_q, recent_d;
	logic [7:0]   tb_q, tb_d;
	logic [7:0]   hb_q, hb_d;
	logic [7:0]   hs_q, hs_d;
	match_flags_t flags_q, flags_d;
	logic         sent_q, sent_d;

	logic [7:0] b;
	logic [7:0] h1, len1, stop1, len2, stop2;
	logic       ok1, ok2, host_hit;

	assign b = item.data_byte;

	// Line one end: h1 is the position of the space before "HTTP/"
	assign h1 = pos_q - 8'd5;
	assign len1 = h1 - tb_q - 8'd1;
	assign ok1 = (h1 > tb_q) && (len1 >= 8'd1) && (len1 <= MAX_LINE) && !flags_q.slash
		&& flags_q.begin_seen && (hb_q < h1);
	assign stop1 = flags_q.stop ? hs_q : h1;

	// Line two end on its newline
	assign len2 = pos_q - tb_q;
	assign ok2 = (len2 >= 8'd1) && (len2 <= MAX_LINE) && flags_q.colon_ok
		&& flags_q.begin_seen;
	assign stop2 = flags_q.stop ? hs_q : pos_q;
	assign host_hit = ((recent_q[31:0] | CASE_FOLD) == PAT_HOST);

	// Next state for one byte
	always_comb begin
		ph_d = ph_q;
		tb_d = tb_q;
		hb_d = hb_q;
		hs_d = hs_q;
		flags_d = flags_q;
		sent_d = sent_q;
		recent_d = recent_q;
		pos_d = (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;
		if (pos_q < WINDOW) begin
			recent_d = {recent_q[31:0], b};
			unique case (ph_q)
				PH_PRE: begin
					if (b == CH_SPACE) begin
						tb_d = pos_q;
						flags_d = '0;
						ph_d = PH_TARGET;
					end else if (b == CH_NL) begin
						ph_d = PH_LINE2;
						tb_d = pos_q + 8'd1;
						hb_d = '0;
						hs_d = '0;
						flags_d = '0;
						sent_d = 1'b0;
					end
				end
				PH_TARGET: begin
					if (b == CH_NL) begin
						ph_d = PH_LINE2;
						tb_d = pos_q + 8'd1;
						hb_d = '0;
						hs_d = '0;
						flags_d = '0;
						sent_d = 1'b0;
					end else if (recent_q == PAT_HTTP && b == CH_SLASH) begin
						ph_d = PH_WAIT;
						if (ok1) begin
							hs_d = stop1;
							sent_d = (stop1 > hb_q);
						end else begin
							sent_d = 1'b0;
						end
					end else begin
						// target scan
						if (pos_q == tb_q + 8'd1 && b == CH_SLASH)
							flags_d.slash = 1'b1;
						if (!flags_q.scheme && flags_q.begin_seen
							&& recent_q[15:0] == PAT_SCHEME && b == CH_SLASH) begin
							flags_d.scheme = 1'b1;
							flags_d.stop = 1'b0;
							hb_d = pos_q + 8'd1;
						end else if (!flags_q.begin_seen) begin
							if (b != CH_SPACE) begin
								flags_d.begin_seen = 1'b1;
								hb_d = pos_q;
								if (b == CH_SLASH) begin
									flags_d.stop = 1'b1;
									hs_d = pos_q;
								end
							end
						end else if (!flags_q.stop && (b == CH_SLASH || b == CH_SPACE)) begin
							flags_d.stop = 1'b1;
							hs_d = pos_q;
						end
					end
				end
				PH_WAIT: begin
					if (b == CH_NL) begin
						if (sent_q) begin
							ph_d = PH_DONE;
						end else begin
							ph_d = PH_LINE2;
							tb_d = pos_q + 8'd1;
							hb_d = '0;
							hs_d = '0;
							flags_d = '0;
							sent_d = 1'b0;
						end
					end
				end
				PH_LINE2: begin
					if (b == CH_NL) begin
						sent_d = 1'b0;
						if (ok2) begin
							hs_d = stop2;
							sent_d = (stop2 > hb_q);
						end
						ph_d = PH_DONE;
					end else if (!flags_q.colon) begin
						if (b == CH_COLON) begin
							flags_d.colon = 1'b1;
							if (len2 >= 8'd4 && host_hit)
								flags_d.colon_ok = 1'b1;
						end
					end else if (flags_q.colon_ok) begin
						if (!flags_q.begin_seen) begin
							if (b != CH_SPACE) begin
								flags_d.begin_seen = 1'b1;
								hb_d = pos_q;
								if (b == CH_CR) begin
									flags_d.stop = 1'b1;
									hs_d = pos_q;
								end
							end
						end else if (!flags_q.stop && (b == CH_SPACE || b == CH_CR)) begin
							flags_d.stop = 1'b1;
							hs_d = pos_q;
						end
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Result as the state stands after this byte
	always_comb begin
		result = '0;
		if (ph_d == PH_DONE && sent_d && hs_d > hb_d) begin
			result.found = 1'b1;
			result.host_start = hb_d;
			result.host_length = 7'(hs_d - hb_d);
		end
	end

	// State registers; the last byte re-arms the parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_PRE;
			pos_q <= '0;
			recent_q <= '0;
			tb_q <= '0;
			hb_q <= '0;
			hs_q <= '0;
			flags_q <= '0;
			sent_q <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				ph_q <= PH_PRE;
				pos_q <= '0;
				recent_q <= '0;
				tb_q <= '0;
				hb_q <= '0;
				hs_q <= '0;
				flags_q <= '0;
				sent_q <= 1'b0;
			end else begin
				ph_q <= ph_d;
				pos_q <= pos_d;
				recent_q <= recent_d;
				tb_q <= tb_d;
				hb_q <= hb_d;
				hs_q <= hs_d;
				flags_q <= flags_d;
				sent_q <= sent_d;
			end
		end
	end

	// Leaving the first phase takes at least one byte
	a_phase_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != PH_PRE) |-> (pos_q != 8'd0))
		else $error("parser left its first phase without a byte");
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.last_byte) |=> (ph_q == PH_PRE && pos_q == 8'd0))
		else $error("parser did not re-arm after last byte");
	a_scheme_needs_begin: assert property (@(posedge clk) disable iff (!arst_n)
		flags_q.scheme |-> flags_q.begin_seen)
		else $error("scheme seen before target begin");

endmodule

>>> design/http_request_host_sniffer.sv
// A byte is registered in the input stage on acceptance and parsed when it
// advances; a request's result is registered as its last byte advances.
// Throughput: one byte per cycle; a last byte waits only while the previous
// result is held by a stalled receiver.
// Reset (arst_n low) clears the pipeline valids and all parser state; the
// parser also re-arms itself after every byte marked last.
module http_request_host_sniffer import hrhs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  byte_item_t byte_item,
	output logic       host_valid,
	input  logic       host_stall,
	output host_info_t host_info
);

	logic       valid_s1;
	byte_item_t item_s1;
	logic       adv;
	logic       accept;
	host_info_t result;
	logic       valid_q;
	host_info_t info_q;

	// Parse a byte unless it is the last one and the result slot is blocked
	assign adv = valid_s1 && (!item_s1.last_byte || !valid_q || !host_stall);
	assign byte_stall = valid_s1 && !adv;
	assign accept = byte_valid && !byte_stall;

	hrhs_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.result (result)
	);

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_item;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv && item_s1.last_byte) begin
			valid_q <= 1'b1;
		end else if (!host_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_s1.last_byte) begin
			info_q <= result;
		end
	end

	assign host_valid = valid_q;
	assign host_info = info_q;

	a_empty_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !info_q.found) |-> (info_q.host_start == 8'd0 && info_q.host_length == 7'd0))
		else $error("miss transaction carries host bounds");
	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && info_q.found) |-> (info_q.host_length != 7'd0))
		else $error("found transaction with empty host");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && item_s1.last_byte && valid_q && host_stall))
		else $error("input stalled without a blocked result");
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.last_byte) |=> valid_q)
		else $error("last byte produced no result transaction");

endmodule
